@@ hw/rtl/rwt_pkg.sv @@
// ----------------------------------------------------------------------------
// rwt_pkg
// Shared types, constants and key builder for the ranking-with-ties block.
// ----------------------------------------------------------------------------
package rwt_pkg;

    localparam int SCORE_W         = 7;
    localparam int SUM_W           = 10;
    localparam int KEY_W           = 45;
    localparam int ID_W            = 20;
    localparam int TOP_W           = 11;
    localparam int KIND_W          = 2;
    localparam int MAX_RECORDS_DEF = 1024;

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Register index of top_count on the config port
    localparam logic REG_TOP_COUNT = 1'b0;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    record_id;
        logic [SCORE_W-1:0] score_one;
        logic [SCORE_W-1:0] score_two;
        logic [SCORE_W-1:0] score_three;
        logic [SCORE_W-1:0] score_four;
        logic [SCORE_W-1:0] score_five;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0] winner_id;
        logic            no_more;
        logic            final_flag;
        logic            overflow;
    } t_out_word;

    // One stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_rec;

    // Compare unit status
    typedef struct packed {
        logic key_eq;   // keys equal
        logic a_first;  // a ranks ahead of (or ties and stays ahead of) b
    } t_cmp_res;

    // Sum on top, then scores three, two, four, one, five
    function automatic logic [KEY_W-1:0] make_key(input t_in_word w);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(w.score_one) + SUM_W'(w.score_two) + SUM_W'(w.score_three)
            + SUM_W'(w.score_four) + SUM_W'(w.score_five);
        return {sum, w.score_three, w.score_two, w.score_four, w.score_one,
                w.score_five};
    endfunction

endpackage

@@ hw/rtl/top_m_ranking_with_ties.sv @@
// ----------------------------------------------------------------------------
// top_m_ranking_with_ties
// Sorted record store with top-M selection and tie extension.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Word
//  -------  ---  -------------------  -----------------------------------
//  in       in   i_in_valid/o_in_ready  kind, record_id, five scores
//  out      out  o_out_valid/i_out_ready winner_id, no_more, final_flag,
//                                        overflow
//  cfg      in   psel/penable/pready  top_count at byte address 0
//
//  A load into an empty store is written on accept; otherwise each stored
//  record ranking after it shifts down a place first. A fetch does three
//  reads on the single read port (registered data), then emits; a dropped
//  load goes to emit. The insertion shift moves one entry per cycle.
//  Reset: synchronous, active low; count, fetch pointer and overflow flag go
//  to zero, top_count to 1. Stalls: a finished word waits in the output
//  register; the next item is taken meanwhile and holds in its emit step only
//  if it also has a word.
//
module top_m_ranking_with_ties #(
    parameter int MAX_RECORDS = rwt_pkg::MAX_RECORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rwt_pkg::t_in_word   i_in_data,
    // result words
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rwt_pkg::t_out_word  o_out_data,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rwt_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    // top_count register
    logic [TOP_W-1:0] r_top;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOP_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TOP_W'(1);
        end else if (cfg_wr) begin
            r_top <= pwdata[TOP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOP_COUNT) ? 32'(r_top) : '0;

    // memory and shared compare unit hookup
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_rec          mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_rec          mem_rdata;
    t_rec          cmp_a, cmp_b;
    t_cmp_res      cmp_res;

    rwt_ctrl #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_top_count (r_top),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata),
        .o_cmp_a     (cmp_a),
        .o_cmp_b     (cmp_b),
        .i_cmp       (cmp_res)
    );

    rwt_store #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rwt_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

endmodule

@@ hw/rtl/rwt_store.sv @@
// ----------------------------------------------------------------------------
// rwt_store
// Sorted record memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rwt_store #(
    parameter int MAX_RECORDS = rwt_pkg::MAX_RECORDS_DEF,
    parameter int AW          = $clog2(MAX_RECORDS)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rwt_pkg::t_rec   i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output rwt_pkg::t_rec   o_rdata
);
    import rwt_pkg::*;

    t_rec r_mem [MAX_RECORDS];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rwt_cmp.sv @@
// ----------------------------------------------------------------------------
// rwt_cmp
// Shared rank compare: key descending, id ascending on equal keys.
// ----------------------------------------------------------------------------
module rwt_cmp (
    input  rwt_pkg::t_rec     i_a,
    input  rwt_pkg::t_rec     i_b,
    output rwt_pkg::t_cmp_res o_res
);
    import rwt_pkg::*;

    logic key_gt;
    logic key_eq;

    assign key_gt = i_a.key > i_b.key;
    assign key_eq = i_a.key == i_b.key;

    always_comb begin
        o_res.key_eq  = key_eq;
        o_res.a_first = key_gt || (key_eq && (i_a.id <= i_b.id));
    end

endmodule

@@ hw/rtl/rwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rwt_ctrl
// Sequencer: insertion shift for loads, three-read tie check for fetches.
// ----------------------------------------------------------------------------
module rwt_ctrl #(
    parameter int MAX_RECORDS = rwt_pkg::MAX_RECORDS_DEF,
    parameter int AW          = $clog2(MAX_RECORDS),
    parameter int CW          = $clog2(MAX_RECORDS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rwt_pkg::t_in_word         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output rwt_pkg::t_out_word        o_out_data,
    input  logic [rwt_pkg::TOP_W-1:0] i_top_count,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output rwt_pkg::t_rec             o_wdata,
    output logic [AW-1:0]             o_raddr,
    input  rwt_pkg::t_rec             i_rdata,
    output rwt_pkg::t_rec             o_cmp_a,
    output rwt_pkg::t_rec             o_cmp_b,
    input  rwt_pkg::t_cmp_res         i_cmp
);
    import rwt_pkg::*;

    localparam int WW = ((CW > TOP_W) ? CW : TOP_W) + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS_CMP = 3'd1;
    localparam logic [2:0] ST_INS_PUT = 3'd2;
    localparam logic [2:0] ST_FET_REF = 3'd3;
    localparam logic [2:0] ST_FET_CUR = 3'd4;
    localparam logic [2:0] ST_FET_NXT = 3'd5;
    localparam logic [2:0] ST_EMIT    = 3'd6;

    logic [2:0]      r_state,   n_state;
    logic [CW-1:0]   r_cnt,     n_cnt;
    logic [CW-1:0]   r_pos,     n_pos;
    logic            r_drop,    n_drop;
    logic [AW-1:0]   r_j,       n_j;
    t_rec            r_opnd,    n_opnd;
    logic            r_cur_eq,  n_cur_eq;
    logic [ID_W-1:0] r_cur_id,  n_cur_id;
    t_out_word       r_res,     n_res;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out,     n_out;

    logic          accept;
    logic          full;
    logic [WW-1:0] cnt_w, pos_w, pos1_w, top_w;
    logic          in_list;
    logic          is_last;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign full   = r_cnt == CW'(MAX_RECORDS);
    assign cnt_w  = WW'(r_cnt);
    assign pos_w  = WW'(r_pos);
    assign pos1_w = pos_w + WW'(1);
    assign top_w  = WW'(i_top_count);

    // Tie extension: past rank top_count an entry stays listed while its key
    // matches the key at rank top_count.
    assign in_list = (i_top_count != '0) && (pos_w < cnt_w) && ((pos_w < top_w) || r_cur_eq);
    assign is_last = in_list && ((pos1_w == cnt_w) || ((pos1_w >= top_w) && !i_cmp.key_eq));

    assign o_cmp_a = i_rdata;
    assign o_cmp_b = r_opnd;

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_data.kind == KIND_FETCH) begin
                    o_raddr = AW'(i_top_count - TOP_W'(1));
                end else begin
                    o_raddr = AW'(r_cnt - CW'(1));
                end
            end
            ST_INS_CMP: o_raddr = r_j - AW'(2);
            ST_FET_REF: o_raddr = AW'(r_pos);
            ST_FET_CUR: o_raddr = AW'(r_pos + CW'(1));
            default:    o_raddr = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_drop      = r_drop;
        n_j         = r_j;
        n_opnd      = r_opnd;
        n_cur_eq    = r_cur_eq;
        n_cur_id    = r_cur_id;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_we        = 1'b0;
        o_waddr     = r_j;
        o_wdata     = r_opnd;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_data.kind)
                        KIND_LOAD: begin
                            if (full) begin
                                n_drop  = 1'b1;
                                n_res   = '{winner_id: '0, no_more: 1'b0,
                                            final_flag: 1'b0, overflow: 1'b1};
                                n_state = ST_EMIT;
                            end else begin
                                n_opnd = '{key: make_key(i_in_data), id: i_in_data.record_id};
                                n_pos  = '0;
                                if (r_cnt == '0) begin
                                    o_we    = 1'b1;
                                    o_waddr = '0;
                                    o_wdata = '{key: make_key(i_in_data),
                                                id: i_in_data.record_id};
                                    n_cnt   = CW'(1);
                                end else begin
                                    n_j     = AW'(r_cnt);
                                    n_state = ST_INS_CMP;
                                end
                            end
                        end
                        KIND_FETCH: n_state = ST_FET_REF;
                        KIND_CLEAR: begin
                            n_cnt  = '0;
                            n_pos  = '0;
                            n_drop = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INS_CMP: begin
                // read data holds entry r_j-1
                o_we = 1'b1;
                if (i_cmp.a_first) begin
                    o_wdata = r_opnd;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = ST_IDLE;
                end else begin
                    o_wdata = i_rdata;
                    n_j     = r_j - AW'(1);
                    if (r_j == AW'(1)) begin
                        n_state = ST_INS_PUT;
                    end
                end
            end
            ST_INS_PUT: begin
                o_we    = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                n_state = ST_IDLE;
            end
            ST_FET_REF: begin
                n_opnd  = i_rdata;
                n_state = ST_FET_CUR;
            end
            ST_FET_CUR: begin
                n_cur_eq = i_cmp.key_eq;
                n_cur_id = i_rdata.id;
                n_state  = ST_FET_NXT;
            end
            ST_FET_NXT: begin
                if (in_list) begin
                    n_res = '{winner_id: r_cur_id, no_more: 1'b0,
                              final_flag: is_last, overflow: r_drop};
                    n_pos = r_pos + CW'(1);
                end else begin
                    n_res = '{winner_id: '0, no_more: 1'b1,
                              final_flag: 1'b0, overflow: r_drop};
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_opnd   <= n_opnd;
        r_cur_eq <= n_cur_eq;
        r_cur_id <= n_cur_id;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/rwt_checker.sv @@
// ----------------------------------------------------------------------------
// rwt_checker
// Port-level checks for the ranking block, bound to the top level.
// ----------------------------------------------------------------------------
module rwt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input rwt_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rwt_pkg::t_out_word o_out_data
);
    import rwt_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // exhausted list reports no id and no last mark
    a_no_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_more |->
            (o_out_data.winner_id == '0) && !o_out_data.final_flag)
        else $error("no_more word carries id or final mark");

    // a fetch always keeps the block busy for the next cycle
    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.kind == KIND_FETCH) |=> !o_in_ready)
        else $error("ready after fetch accept");

    // a clear finishes in its accept cycle
    a_clear_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.kind == KIND_CLEAR) |=> o_in_ready)
        else $error("busy after clear accept");

endmodule

bind top_m_ranking_with_ties rwt_checker u_rwt_checker (.*);

@@ dv/tb_top_m_ranking_with_ties.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_m_ranking_with_ties
// Self-checking bench for the ranked record store with tie extension.
// Words go in and out over valid/ready with random idles on both sides;
// top_count is programmed over the APB port between phases and read back.
// A scoreboard keeps its own sorted copy of the store and predicts every
// result word; results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top_m_ranking_with_ties;
    import rwt_pkg::*;

    localparam int CAP      = MAX_RECORDS_DEF;
    localparam int LIMIT    = 1000000;   // cycles before the run is called hung
    localparam int IDLE_PCT = 36;
    localparam int RAND_WORDS = 120;
    localparam int IN_W     = $bits(t_in_word);
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;   // ignored by the block
    localparam logic [2:0] ADDR_TOP_COUNT = 3'(4 * int'(REG_TOP_COUNT));

    // ------------------------------------------------------------------------
    // Ranking scoreboard: sorted copy of the store plus expected result words
    // ------------------------------------------------------------------------
    class ranking_board;
        logic [KEY_W-1:0] keys [CAP];
        logic [ID_W-1:0]  ids  [CAP];
        int               count;
        int               fetch_pos;
        int               top;
        bit               dropped;
        t_out_word        waiting [$];
        int               mismatches;

        function new();
            count      = 0;
            fetch_pos  = 0;
            top        = 1;
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch @%0t: %s", $time, msg);
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        // score total on top, then three, two, four, one, five
        function logic [KEY_W-1:0] key_of(t_in_word w);
            logic [SUM_W-1:0] total;
            total = SUM_W'(w.score_one) + SUM_W'(w.score_two) + SUM_W'(w.score_three)
                  + SUM_W'(w.score_four) + SUM_W'(w.score_five);
            return {total, w.score_three, w.score_two, w.score_four, w.score_one,
                    w.score_five};
        endfunction

        // first top ranks, stretched over records tied with the last of them
        function int selected_len();
            int len;
            if (top == 0)
                return 0;
            if (top >= count)
                return count;
            len = top;
            while (len < count && keys[len] == keys[top-1])
                len++;
            return len;
        endfunction

        function void expect_word(logic [ID_W-1:0] id, logic none, logic last);
            t_out_word e;
            e.winner_id  = id;
            e.no_more    = none;
            e.final_flag = last;
            e.overflow   = dropped;
            waiting.push_back(e);
        endfunction

        function void note_word(t_in_word w);
            logic [KEY_W-1:0] k;
            int pos;
            int len;
            case (w.kind)
                KIND_LOAD: begin
                    if (count >= CAP) begin
                        dropped = 1'b1;
                        expect_word('0, 1'b0, 1'b0);
                    end else begin
                        k   = key_of(w);
                        pos = 0;
                        // equal key and id: newcomer goes behind
                        while (pos < count && (keys[pos] > k ||
                               (keys[pos] == k && ids[pos] <= w.record_id)))
                            pos++;
                        for (int j = count; j > pos; j--) begin
                            keys[j] = keys[j-1];
                            ids[j]  = ids[j-1];
                        end
                        keys[pos] = k;
                        ids[pos]  = w.record_id;
                        count++;
                        fetch_pos = 0;
                    end
                end
                KIND_FETCH: begin
                    len = selected_len();
                    if (fetch_pos < len) begin
                        expect_word(ids[fetch_pos], 1'b0, (fetch_pos + 1) == len);
                        fetch_pos++;
                    end else begin
                        expect_word('0, 1'b1, 1'b0);
                    end
                end
                KIND_CLEAR: begin
                    count     = 0;
                    fetch_pos = 0;
                    dropped   = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (waiting.size() == 0) begin
                flag($sformatf("unexpected word id %h no_more %b final %b overflow %b",
                               got.winner_id, got.no_more, got.final_flag, got.overflow));
                return;
            end
            want = waiting.pop_front();
            if (got.winner_id !== want.winner_id || got.no_more !== want.no_more ||
                got.final_flag !== want.final_flag || got.overflow !== want.overflow)
                flag($sformatf("exp id %h nm %b fin %b ovf %b / got id %h nm %b fin %b ovf %b",
                               want.winner_id, want.no_more, want.final_flag,
                               want.overflow, got.winner_id, got.no_more,
                               got.final_flag, got.overflow));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    ranking_board board = new();

    int          cycle_count = 0;
    int          words_sent  = 0;    // accepted words, ignored kind excluded
    bit          no_idle     = 1'b0; // both sides run flat out while set
    logic [6:0]  phase_score = '0;   // score value shared within a phase
    t_in_word    prev_rec    = '0;   // last random load, reused to force ties

    top_m_ranking_with_ties i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: random back-pressure unless in a flat-out stretch
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result monitor and hang guard. Signals are read as they were
    // before this edge, so the handshake seen here is the one that fired.
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_word(o_out_data);
        if (cycle_count >= LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    // kind forced, every other field random (ignored fields get noise too)
    function automatic t_in_word rand_word(logic [KIND_W-1:0] kind);
        t_in_word w;
        w      = IN_W'({$urandom(), $urandom()});
        w.kind = kind;
        return w;
    endfunction

    function automatic t_in_word load_of(logic [ID_W-1:0] id, logic [6:0] s1,
                                         logic [6:0] s2, logic [6:0] s3,
                                         logic [6:0] s4, logic [6:0] s5);
        t_in_word w;
        w             = '0;
        w.kind        = KIND_LOAD;
        w.record_id   = id;
        w.score_one   = s1;
        w.score_two   = s2;
        w.score_three = s3;
        w.score_four  = s4;
        w.score_five  = s5;
        return w;
    endfunction

    // biased toward extremes and a per-phase value so keys collide
    function automatic logic [6:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd127;
            2, 3:    return phase_score;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic t_in_word pick_record();
        t_in_word w;
        w = rand_word(KIND_LOAD);
        if ($urandom_range(0, 1) == 1)
            w.record_id = 20'($urandom_range(0, 7));   // small id pool
        if ($urandom_range(0, 9) < 3) begin
            // same scores as the last load: equal key, id decides
            w.score_one   = prev_rec.score_one;
            w.score_two   = prev_rec.score_two;
            w.score_three = prev_rec.score_three;
            w.score_four  = prev_rec.score_four;
            w.score_five  = prev_rec.score_five;
        end else begin
            w.score_one   = pick_score();
            w.score_two   = pick_score();
            w.score_three = pick_score();
            w.score_four  = pick_score();
            w.score_five  = pick_score();
        end
        prev_rec = w;
        return w;
    endfunction

    function automatic logic [TOP_W-1:0] pick_top();
        case ($urandom_range(0, 9))
            0:       return '0;          // nothing selected
            1:       return 11'h7FF;     // field maximum
            2:       return 11'd1024;
            3:       return 11'd1;
            default: return 11'($urandom_range(1, 12));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Valid is left high on return; the next call either keeps it high for
    // a back-to-back word or drops it for an idle gap, one update per edge.
    task automatic push_word(input t_in_word w);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(w);
        if (w.kind != KIND_NONE)
            words_sent++;
    endtask

    // Hold input until every result is back, then cover a load still
    // shifting the store (one entry per cycle) before touching config.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (board.count + 8) @(posedge i_clk);
    endtask

    // APB write of top_count, then read back; psel stays up between the two
    task automatic program_top_count(input logic [TOP_W-1:0] value);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOP_COUNT;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.top = int'(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(value))
            board.flag($sformatf("top_count readback exp %h got %h", 32'(value), got));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int rand_base;
        int phase;
        int n;
        int fetches;
        int pick;
        int grp;
        logic [6:0] sc;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty fetch, extreme records, tie order by id, equal key
        // and id, same total with different components, reset top_count 1.
        push_word(rand_word(KIND_FETCH));
        push_word(load_of(20'h00000,   0,   0,   0,   0,   0));
        push_word(load_of(20'hFFFFF, 127, 127, 127, 127, 127));
        push_word(load_of(20'd5,      10,  20,  30,  40,  50));
        push_word(load_of(20'd3,      10,  20,  30,  40,  50));
        push_word(load_of(20'd5,      10,  20,  30,  40,  50));
        push_word(load_of(20'd9,      50,  40,  30,  20,  10));
        repeat (2) push_word(rand_word(KIND_FETCH));   // single winner, then none
        settle();
        program_top_count(11'd3);                      // rank 3 tied with two more
        repeat (6) push_word(rand_word(KIND_FETCH));
        push_word(load_of(20'd1, 127, 127, 127, 127, 126));  // load restarts fetch
        push_word(rand_word(KIND_FETCH));
        push_word(rand_word(KIND_NONE));               // ignored kind
        push_word(rand_word(KIND_FETCH));
        settle();
        program_top_count('0);                         // empty selection
        push_word(rand_word(KIND_FETCH));
        settle();
        program_top_count(11'h7FF);                    // beyond record count
        repeat (2) push_word(rand_word(KIND_FETCH));
        push_word(rand_word(KIND_CLEAR));
        push_word(rand_word(KIND_FETCH));

        // Random phases: small stores, random top_count, drain the list and
        // run past its end, with loads, clears and noise mixed into fetching.
        rand_base = words_sent;
        phase     = 0;
        while (words_sent - rand_base < RAND_WORDS) begin
            settle();
            no_idle     = (phase == 4) || ($urandom_range(0, 9) == 0);
            phase_score = 7'($urandom_range(0, 127));
            program_top_count(pick_top());
            if (board.count > 40 || $urandom_range(0, 9) < 7)
                push_word(rand_word(KIND_CLEAR));
            n = $urandom_range(1, 16);
            repeat (n) push_word(pick_record());
            fetches = board.selected_len() + $urandom_range(1, 3);
            repeat (fetches) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    push_word(pick_record());
                else if (pick < 12)
                    push_word(rand_word(KIND_NONE));
                else if (pick < 14)
                    push_word(rand_word(KIND_CLEAR));
                else
                    push_word(rand_word(KIND_FETCH));
            end
            phase++;
        end

        // Full store: records arrive already in rank order (four score
        // groups, ids rising) so each lands at the tail, then overflow.
        settle();
        no_idle = 1'b1;
        program_top_count(11'($urandom_range(1, CAP - 1)));
        push_word(rand_word(KIND_CLEAR));
        for (int i = 0; i < CAP; i++) begin
            grp = i / (CAP / 4);
            sc  = 7'(120 - 30 * grp);
            push_word(load_of(20'((i << 10) | $urandom_range(0, 1023)), sc, sc, sc, sc, sc));
        end
        no_idle = 1'b0;
        push_word(pick_record());                      // dropped, overflow word
        repeat (4) push_word(rand_word(KIND_FETCH));   // head of the full list
        push_word(pick_record());
        push_word(rand_word(KIND_CLEAR));              // clears the sticky flag
        push_word(rand_word(KIND_FETCH));

        settle();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rwt_pkg.sv
hw/rtl/rwt_store.sv
hw/rtl/rwt_cmp.sv
hw/rtl/rwt_ctrl.sv
hw/rtl/top_m_ranking_with_ties.sv
hw/rtl/rwt_checker.sv
dv/tb_top_m_ranking_with_ties.sv
